// ===== rtl/core/tah_pkg.sv =====
package tah_pkg;

   localparam int unsigned TempWidth  = 11;
   localparam int unsigned EventWidth = 3;
   localparam int unsigned IndWidth   = 2;
   localparam int unsigned StateWidth = 4;
   localparam int unsigned CsrIdxWidth = 2;

   typedef logic signed [TempWidth-1:0] temp_type;

   typedef enum logic [StateWidth-1:0] {
      ST_N1  = 4'd0,
      ST_N2  = 4'd1,
      ST_N3  = 4'd2,
      ST_WH1 = 4'd3,
      ST_WH2 = 4'd4,
      ST_CH  = 4'd5,
      ST_WL1 = 4'd6,
      ST_WL2 = 4'd7,
      ST_CL  = 4'd8
   } alarm_state_type;

   typedef enum logic [EventWidth-1:0] {
      EV_NONE = 3'd0,
      EV_HW   = 3'd1,
      EV_LW   = 3'd2,
      EV_HC   = 3'd3,
      EV_LC   = 3'd4
   } alarm_event_type;

   typedef enum logic [IndWidth-1:0] {
      IND_KEEP = 2'd0,
      IND_NORM = 2'd1,
      IND_WARN = 2'd2,
      IND_CRIT = 2'd3
   } ind_mode_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_HIGH_CRITICAL = 2'd0,
      CSR_HIGH_WARNING  = 2'd1,
      CSR_LOW_CRITICAL  = 2'd2,
      CSR_LOW_WARNING   = 2'd3
   } csr_index_type;

   localparam temp_type HighReset = 11'sd1023;
   localparam temp_type LowReset  = -11'sd1024;

endpackage

// ===== rtl/core/temperature_alarm_hysteresis_fsm.sv =====
// Stages: a request is registered in s1, then its response in the rsp_* registers.
// Throughput: one transaction per cycle while rsp_* is not stalled; the single
// alarm state register is fed back through combinational next-state logic.
// Reset: synchronous, active high; empties both pipeline stages, returns the
// machine to the first normal state and restores the four thresholds.
module temperature_alarm_hysteresis_fsm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [tah_pkg::TempWidth-1:0] req_temperature,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tah_pkg::EventWidth-1:0]    rsp_alarm_event,
   output logic [tah_pkg::IndWidth-1:0]      rsp_indicator_mode,
   input  logic                              csr_wr_en,
   input  logic [tah_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [tah_pkg::TempWidth-1:0]     csr_wdata
);
   import tah_pkg::*;

   temp_type        high_critical_ff, high_warning_ff, low_critical_ff, low_warning_ff;
   logic            s1_valid_ff;
   temp_type        s1_temp_ff;
   logic            s1_restart_ff;
   alarm_state_type state_ff, state_in;
   logic            rsp_valid_ff;
   alarm_event_type rsp_event_ff, event_in;
   ind_mode_type    rsp_ind_ff, ind_in;

   logic out_free, advance, req_accept;
   logic ge_hc, ge_hw, le_lc, le_lw;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign ge_hc = s1_temp_ff >= high_critical_ff;
   assign ge_hw = s1_temp_ff >= high_warning_ff;
   assign le_lc = s1_temp_ff <= low_critical_ff;
   assign le_lw = s1_temp_ff <= low_warning_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_critical_ff <= HighReset;
         high_warning_ff  <= HighReset;
         low_critical_ff  <= LowReset;
         low_warning_ff   <= LowReset;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_HIGH_CRITICAL: high_critical_ff <= temp_type'(csr_wdata);
            CSR_HIGH_WARNING:  high_warning_ff  <= temp_type'(csr_wdata);
            CSR_LOW_CRITICAL:  low_critical_ff  <= temp_type'(csr_wdata);
            CSR_LOW_WARNING:   low_warning_ff   <= temp_type'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_temp_ff    <= req_temperature;
         s1_restart_ff <= req_restart;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (s1_restart_ff) begin
         state_in = ST_N1;
      end else begin
         unique case (state_ff)
            ST_N2: begin
               if (ge_hw)      state_in = ST_WH1;
               else if (le_lw) state_in = ST_WL1;
            end
            ST_N3: begin
               if (le_lw)      state_in = ST_WL1;
               else if (ge_hw) state_in = ST_WH1;
            end
            ST_WH1, ST_WH2: begin
               if (ge_hc)       state_in = ST_CH;
               else if (!ge_hw) state_in = ST_N3;
            end
            ST_CH: begin
               if (!ge_hc) state_in = ST_WH2;
            end
            ST_WL1: begin
               if (le_lc)       state_in = ST_CL;
               else if (!le_lw) state_in = ST_N2;
            end
            ST_WL2: begin
               if (le_lc && s1_temp_ff != low_critical_ff) state_in = ST_CL;
               else if (!le_lw)                            state_in = ST_N3;
            end
            ST_CL: begin
               if (!le_lc) state_in = ST_WL2;
            end
            default: begin
               if (ge_hw)      state_in = ST_WH1;
               else if (le_lw) state_in = ST_WL1;
               else            state_in = ST_N1;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      event_in = EV_NONE;
      ind_in   = IND_KEEP;
      if (!s1_restart_ff) begin
         unique case (state_ff)
            ST_N2: begin
               if (ge_hw) begin
                  event_in = EV_HW;
                  ind_in   = IND_WARN;
               end else if (le_lw) begin
                  ind_in = IND_WARN;
               end else begin
                  ind_in = IND_NORM;
               end
            end
            ST_N3: begin
               if (le_lw) begin
                  event_in = EV_LW;
                  ind_in   = IND_WARN;
               end else if (ge_hw) begin
                  ind_in = IND_WARN;
               end else begin
                  ind_in = IND_NORM;
               end
            end
            ST_WH1: begin
               if (ge_hc) begin
                  event_in = EV_HC;
                  ind_in   = IND_CRIT;
               end else if (!ge_hw) begin
                  ind_in = IND_NORM;
               end else begin
                  ind_in = IND_WARN;
               end
            end
            ST_WH2: begin
               if (ge_hc) ind_in = IND_CRIT;
               else       ind_in = IND_NORM;
            end
            ST_CH: begin
               if (!ge_hc) ind_in = IND_WARN;
               else        ind_in = IND_CRIT;
            end
            ST_WL1: begin
               if (le_lc) begin
                  event_in = EV_LC;
                  ind_in   = IND_CRIT;
               end else if (!le_lw) begin
                  ind_in = IND_NORM;
               end else begin
                  ind_in = IND_WARN;
               end
            end
            ST_WL2: begin
               if (le_lc && s1_temp_ff != low_critical_ff) ind_in = IND_CRIT;
               else if (!le_lw)                            ind_in = IND_NORM;
               else                                        ind_in = IND_WARN;
            end
            ST_CL: begin
               if (!le_lc) ind_in = IND_WARN;
               else        ind_in = IND_CRIT;
            end
            default: begin
               if (ge_hw) begin
                  event_in = EV_HW;
                  ind_in   = IND_WARN;
               end else if (le_lw) begin
                  event_in = EV_LW;
                  ind_in   = IND_WARN;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_N1;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_event_ff <= event_in;
         rsp_ind_ff   <= ind_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_alarm_event    = rsp_event_ff;
   assign rsp_indicator_mode = rsp_ind_ff;

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("response raised without a staged transaction");

   a_event_shows_alarm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_event_ff != EV_NONE) |->
         (rsp_ind_ff == IND_WARN || rsp_ind_ff == IND_CRIT))
      else $error("alarm event without warning or critical indicator");

   a_restart_to_n1: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_restart_ff) |=> (state_ff == ST_N1))
      else $error("restart did not return to first normal state");

   a_critical_from_warning: assert property (@(posedge clock) disable iff (reset)
      (advance && (event_in == EV_HC || event_in == EV_LC)) |->
         (state_ff == ST_WH1 || state_ff == ST_WL1))
      else $error("critical event outside first warning state");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tah_pkg::*;

   localparam int unsigned IdleLimit = 2000;
   localparam int unsigned HoldCycles = 300;
   localparam int unsigned PhaseCount = 8;
   localparam int unsigned PhaseSamples = 150;
   localparam int Probe [23] = '{
      0, 50, 50, 100, 100, 99, 60, 200, 0, 1023, 0, -50, -60, -100, -1024,
      -99, -100, -101, -99, -49, -50, -49, -50
   };

   typedef struct packed {
      alarm_event_type alarm;
      ind_mode_type    mode;
   } alarm_report_type;

   class alarm_tracker;
      temp_type         hi_crit;
      temp_type         hi_warn;
      temp_type         lo_crit;
      temp_type         lo_warn;
      alarm_state_type  zone;
      alarm_report_type due_reports [$];
      int unsigned      mismatches;

      function new();
         hi_crit = HighReset;
         hi_warn = HighReset;
         lo_crit = LowReset;
         lo_warn = LowReset;
         zone = ST_N1;
         mismatches = 0;
      endfunction

      function void set_threshold(csr_index_type idx, temp_type val);
         case (idx)
            CSR_HIGH_CRITICAL: hi_crit = val;
            CSR_HIGH_WARNING:  hi_warn = val;
            CSR_LOW_CRITICAL:  lo_crit = val;
            CSR_LOW_WARNING:   lo_warn = val;
            default: ;
         endcase
      endfunction

      function void note_sample(temp_type t, logic restart);
         alarm_state_type nxt;
         alarm_event_type ev;
         ind_mode_type    ind;
         ev = EV_NONE;
         ind = IND_KEEP;
         nxt = zone;
         if (restart) begin
            nxt = ST_N1;
         end else begin
            case (zone)
               ST_N2: begin
                  if (t >= hi_warn) begin
                     nxt = ST_WH1; ev = EV_HW; ind = IND_WARN;
                  end else if (t <= lo_warn) begin
                     nxt = ST_WL1; ind = IND_WARN;
                  end else ind = IND_NORM;
               end
               ST_N3: begin
                  if (t <= lo_warn) begin
                     nxt = ST_WL1; ev = EV_LW; ind = IND_WARN;
                  end else if (t >= hi_warn) begin
                     nxt = ST_WH1; ind = IND_WARN;
                  end else ind = IND_NORM;
               end
               ST_WH1: begin
                  if (t >= hi_crit) begin
                     nxt = ST_CH; ev = EV_HC; ind = IND_CRIT;
                  end else if (t < hi_warn) begin
                     nxt = ST_N3; ind = IND_NORM;
                  end else ind = IND_WARN;
               end
               ST_WH2: begin
                  if (t >= hi_crit) begin
                     nxt = ST_CH; ind = IND_CRIT;
                  end else if (t < hi_warn) begin
                     nxt = ST_N3; ind = IND_NORM;
                  end else ind = IND_NORM;
               end
               ST_CH: begin
                  if (t < hi_crit) begin
                     nxt = ST_WH2; ind = IND_WARN;
                  end else ind = IND_CRIT;
               end
               ST_WL1: begin
                  if (t <= lo_crit) begin
                     nxt = ST_CL; ev = EV_LC; ind = IND_CRIT;
                  end else if (t > lo_warn) begin
                     nxt = ST_N2; ind = IND_NORM;
                  end else ind = IND_WARN;
               end
               ST_WL2: begin
                  if (t < lo_crit) begin
                     nxt = ST_CL; ind = IND_CRIT;
                  end else if (t > lo_warn) begin
                     nxt = ST_N3; ind = IND_NORM;
                  end else ind = IND_WARN;
               end
               ST_CL: begin
                  if (t > lo_crit) begin
                     nxt = ST_WL2; ind = IND_WARN;
                  end else ind = IND_CRIT;
               end
               default: begin
                  nxt = ST_N1;
                  if (t >= hi_warn) begin
                     nxt = ST_WH1; ev = EV_HW; ind = IND_WARN;
                  end else if (t <= lo_warn) begin
                     nxt = ST_WL1; ev = EV_LW; ind = IND_WARN;
                  end
               end
            endcase
         end
         zone = nxt;
         due_reports.push_back('{alarm: ev, mode: ind});
      endfunction

      function void check_report(logic [EventWidth-1:0] ev, logic [IndWidth-1:0] ind);
         alarm_report_type want;
         if (due_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected alarm report: event %0d mode %0d", ev, ind);
         end else begin
            want = due_reports.pop_front();
            if (ev !== want.alarm || ind !== want.mode) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected event %0d mode %0d, got event %0d mode %0d",
                           want.alarm, want.mode, ev, ind);
            end
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [TempWidth-1:0] req_temperature = '0;
   logic                       req_restart = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [EventWidth-1:0]      rsp_alarm_event;
   logic [IndWidth-1:0]        rsp_indicator_mode;
   logic                       csr_wr_en = 1'b0;
   logic [CsrIdxWidth-1:0]     csr_index = '0;
   logic [TempWidth-1:0]       csr_wdata = '0;

   alarm_tracker tracker;
   logic         calm = 1'b1;
   logic         hold_request = 1'b0;
   int unsigned  idle_cycles = 0;

   temperature_alarm_hysteresis_fsm dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_temperature    (req_temperature),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_alarm_event    (rsp_alarm_event),
      .rsp_indicator_mode (rsp_indicator_mode),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic temp_type clamp_temp(int v);
      if (v > 1023) v = 1023;
      if (v < -1024) v = -1024;
      return temp_type'(v);
   endfunction

   function automatic temp_type next_temperature(temp_type prev);
      int unsigned r;
      int          jitter;
      r = $urandom_range(0, 99);
      jitter = int'($urandom_range(0, 6)) - 3;
      if (r < 55) return clamp_temp(int'(prev) + int'($urandom_range(0, 80)) - 40);
      if (r < 90) begin
         case ($urandom_range(0, 3))
            0: return clamp_temp(int'(tracker.hi_crit) + jitter);
            1: return clamp_temp(int'(tracker.hi_warn) + jitter);
            2: return clamp_temp(int'(tracker.lo_warn) + jitter);
            default: return clamp_temp(int'(tracker.lo_crit) + jitter);
         endcase
      end
      return clamp_temp(int'($urandom_range(0, 2047)) - 1024);
   endfunction

   task automatic offer_sample(temp_type t, logic restart);
      int unsigned gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_temperature <= t;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      tracker.note_sample(t, restart);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.due_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, temp_type val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      tracker.set_threshold(idx, val);
   endtask

   task automatic write_thresholds(temp_type hc, temp_type hw, temp_type lc, temp_type lw);
      write_csr(CSR_HIGH_CRITICAL, hc);
      write_csr(CSR_HIGH_WARNING, hw);
      write_csr(CSR_LOW_CRITICAL, lc);
      write_csr(CSR_LOW_WARNING, lw);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : rsp_side
      int unsigned hold_left;
      int unsigned run_left;
      hold_left = 0;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HoldCycles;
            run_left = 0;
         end else if (hold_left == 0 && run_left == 0) begin
            hold_left = gap_len();
            run_left = $urandom_range(1, 12);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
            run_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_report(rsp_alarm_event, rsp_indicator_mode);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      temp_type    walk;
      int          lc;
      int          lw;
      int          hw;
      int          hc;
      int unsigned p;
      int unsigned n;
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset thresholds sit at the range extremes
      offer_sample(temp_type'(1023), 1'b0);
      offer_sample(temp_type'(1023), 1'b0);
      offer_sample(temp_type'(-1024), 1'b0);
      offer_sample(temp_type'(0), 1'b1);
      settle();

      write_thresholds(temp_type'(100), temp_type'(50), temp_type'(-100), temp_type'(-50));
      calm = 1'b0;
      foreach (Probe[i]) offer_sample(temp_type'(Probe[i]), 1'b0);
      offer_sample(temp_type'(1023), 1'b1);
      offer_sample(temp_type'(-1024), 1'b0);

      walk = '0;
      for (p = 0; p < PhaseCount; p++) begin
         settle();
         case (p % 4)
            0: begin
               lc = int'($urandom_range(0, 1600)) - 800;
               lw = lc + int'($urandom_range(0, 8));
               hw = lw + int'($urandom_range(0, 30));
               hc = hw + int'($urandom_range(0, 8));
            end
            1: begin
               lc = int'($urandom_range(0, 700)) - 1024;
               lw = lc + int'($urandom_range(0, 200));
               hw = lw + int'($urandom_range(0, 400));
               hc = hw + int'($urandom_range(0, 200));
            end
            2: begin
               lc = int'($urandom_range(0, 2047)) - 1024;
               lw = int'($urandom_range(0, 2047)) - 1024;
               hw = int'($urandom_range(0, 2047)) - 1024;
               hc = int'($urandom_range(0, 2047)) - 1024;
            end
            default: begin
               if (p < 4) begin
                  lc = -1024; lw = -1024; hw = 1023; hc = 1023;
               end else begin
                  lc = 1023; lw = 1023; hw = -1024; hc = -1024;
               end
            end
         endcase
         write_thresholds(clamp_temp(hc), clamp_temp(hw), clamp_temp(lc), clamp_temp(lw));
         calm = (p % 3 == 2);
         for (n = 0; n < PhaseSamples; n++) begin
            if (p == 1 && n == 40) hold_request = 1'b1;
            walk = next_temperature(walk);
            offer_sample(walk, $urandom_range(0, 99) < 3);
         end
      end
      settle();

      if (tracker.mismatches == 0 && tracker.due_reports.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
